// File: rtl/dfs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dfs_pkg
// Shared types and constants of the delimited field splitter: the command
// passed from the classifier to the emitter, and the result record.
// ----------------------------------------------------------------------------
package dfs_pkg;

  // result kinds
  localparam logic [1:0] KIND_BYTE      = 2'd0;
  localparam logic [1:0] KIND_FIELD_END = 2'd1;
  localparam logic [1:0] KIND_LINE      = 2'd2;

  // width of a held-whitespace count, enough for a store of up to 63 entries (default 32)
  localparam int unsigned CNT_W = 6;

  // work for one accepted byte, in emission order:
  // held whitespace, kept byte or field end, then line report
  typedef struct packed {
    logic [15:0]      row;
    logic [7:0]       col;
    logic             has_fe;
    logic             trunc;
    logic             has_byte;
    logic [7:0]       data;
    logic [CNT_W-1:0] flush_cnt;
    logic             has_line;
    logic [7:0]       line_col;
    logic             bracket_err;
    logic             quote_err;
    logic             count_err;
  } cmd_t;

  // one result item
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic [15:0] row;
    logic [7:0]  col;
    logic        trunc;
    logic        bracket_err;
    logic        quote_err;
    logic        count_err;
    logic        last;
  } res_t;

endpackage
`default_nettype wire

// File: rtl/dfs_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dfs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dfs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// File: rtl/dfs_cmd_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dfs_cmd_fifo
// Two-entry command queue between the classifier and the emitter.
// ----------------------------------------------------------------------------
module dfs_cmd_fifo
  import dfs_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  cmd_t      cmd_i,
  input  wire logic pop_i,
  output cmd_t      cmd_o,
  output logic      full_o,
  output logic      empty_o
);

  cmd_t       entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign cmd_o   = entry_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("command pushed into full queue");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i)
    else $error("command popped from empty queue");
`endif

endmodule
`default_nettype wire

// File: rtl/dfs_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dfs_front
// Classifier: holds the configuration and per-line state, takes one byte a
// transfer, stores held whitespace and queues the emission command.
// ----------------------------------------------------------------------------
module dfs_front
  import dfs_pkg::*;
#(
  parameter int unsigned LINE_MAX      = 1024,
  parameter int unsigned PENDING_DEPTH = 32,
  parameter int unsigned AW            = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  // configuration writes
  input  wire logic          cfg_valid_i,
  input  wire logic [2:0]    cfg_index_i,
  input  wire logic [7:0]    cfg_data_i,
  // byte stream
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic [7:0]    in_byte_i,
  input  wire logic          in_eos_i,
  // command queue
  output logic               push_o,
  output cmd_t               cmd_o,
  input  wire logic          fifo_full_i,
  input  wire logic          flush_done_i,
  // whitespace store write port
  output logic               ram_we_o,
  output logic [AW-1:0]      ram_waddr_o,
  output logic [7:0]         ram_wdata_o
);

  localparam int unsigned LLW = $clog2(LINE_MAX + 1);

  localparam logic [2:0] REG_DELIM_MODE = 3'd0;
  localparam logic [2:0] REG_END_MODE   = 3'd1;
  localparam logic [2:0] REG_CHK_BRACE  = 3'd2;
  localparam logic [2:0] REG_CHK_QUOTE  = 3'd3;
  localparam logic [2:0] REG_SKIP_SPACE = 3'd4;
  localparam logic [2:0] REG_CHK_COUNT  = 3'd5;
  localparam logic [2:0] REG_EXP_FIELDS = 3'd6;

  localparam logic [2:0] DM_COMMA_NL    = 3'd0;
  localparam logic [2:0] DM_COMMA_WS    = 3'd1;
  localparam logic [2:0] DM_COMMA_SLASH = 3'd2;
  localparam logic [2:0] DM_POUND       = 3'd3;
  localparam logic [2:0] DM_COMMA_SEMI  = 3'd4;

  localparam logic [1:0] EM_NL    = 2'd0;
  localparam logic [1:0] EM_WS    = 2'd1;
  localparam logic [1:0] EM_SLASH = 2'd2;
  localparam logic [1:0] EM_SEMI  = 2'd3;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_POUND  = 8'h23;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic is_nl(input logic [7:0] c);
    return (c == CH_CR) || (c == CH_LF) || (c == CH_NUL);
  endfunction

  function automatic logic is_delim(input logic [2:0] mode, input logic [7:0] c);
    logic r;
    case (mode)
      DM_COMMA_NL:    r = (c == CH_COMMA) || is_nl(c);
      DM_COMMA_WS:    r = (c == CH_COMMA) || is_nl(c) || is_ws(c);
      DM_COMMA_SLASH: r = (c == CH_COMMA) || is_nl(c) || (c == CH_SLASH);
      DM_POUND:       r = (c == CH_POUND);
      DM_COMMA_SEMI:  r = (c == CH_COMMA) || is_nl(c) || (c == CH_SEMI);
      default:        r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic is_end(input logic [1:0] mode, input logic [7:0] c);
    logic r;
    case (mode)
      EM_NL:    r = is_nl(c);
      EM_WS:    r = is_nl(c) || is_ws(c);
      EM_SLASH: r = is_nl(c) || (c == CH_SLASH);
      EM_SEMI:  r = is_nl(c) || (c == CH_SEMI);
      default:  r = is_nl(c);
    endcase
    return r;
  endfunction

  // configuration
  logic [2:0] delim_mode_q;
  logic [1:0] end_mode_q;
  logic       chk_brace_q, chk_quote_q, skip_space_q, chk_count_q;
  logic [7:0] exp_fields_q;

  // per-line state
  logic [15:0]      row_q, row_d;
  logic [7:0]       col_q, col_d;
  logic [7:0]       depth_q, depth_d;
  logic             in_quote_q, in_quote_d;
  logic             skipping_q, skipping_d;
  logic             stopped_q, stopped_d;
  logic [LLW-1:0]   len_q, len_d;
  logic             started_q, started_d;
  logic [CNT_W-1:0] pcnt_q, pcnt_d;
  logic             povf_q, povf_d;
  logic             flush_busy_q, flush_busy_d;

  logic             accept;
  logic             proc, is_dl, kept, ws_byte, keep_byte, line_end;
  logic [LLW-1:0]   len_inc;

  assign in_ready_o = !fifo_full_i && !flush_busy_q;
  assign accept     = in_valid_i && in_ready_o;

  // byte classification and next state
  always_comb begin
    proc      = !stopped_q && !(skipping_q && is_ws(in_byte_i));
    depth_d   = depth_q;
    in_quote_d = in_quote_q;
    if (proc && chk_brace_q) begin
      if (in_byte_i == CH_LBRACE) begin
        depth_d = depth_q + 8'd1;
      end else if (in_byte_i == CH_RBRACE) begin
        depth_d = depth_q - 8'd1;
      end
    end
    if (proc && chk_quote_q && in_byte_i == CH_QUOTE) begin
      in_quote_d = !in_quote_q;
    end

    is_dl     = proc && (depth_d == 8'd0) && !in_quote_d && is_delim(delim_mode_q, in_byte_i);
    kept      = proc && !is_dl && (in_byte_i != CH_QUOTE);
    ws_byte   = kept && is_ws(in_byte_i);
    keep_byte = kept && !is_ws(in_byte_i);

    col_d      = (is_dl && col_q != 8'hFF) ? col_q + 8'd1 : col_q;
    stopped_d  = stopped_q || (proc && is_end(end_mode_q, in_byte_i));
    skipping_d = proc ? (is_dl && !is_end(end_mode_q, in_byte_i) && skip_space_q)
                      : skipping_q;
    started_d  = is_dl ? 1'b0 : (keep_byte ? 1'b1 : started_q);
    pcnt_d     = pcnt_q;
    povf_d     = is_dl ? 1'b0 : povf_q;
    ram_we_o   = 1'b0;
    if (is_dl || keep_byte) begin
      pcnt_d = '0;
    end else if (ws_byte && started_q) begin
      if (pcnt_q < CNT_W'(PENDING_DEPTH)) begin
        ram_we_o = accept;
        pcnt_d   = pcnt_q + CNT_W'(1);
      end else begin
        povf_d = 1'b1;
      end
    end

    len_inc  = len_q + LLW'(1);
    line_end = (in_byte_i == CH_LF) || (len_inc >= LLW'(LINE_MAX)) || in_eos_i;

    cmd_o.row         = row_q;
    cmd_o.col         = col_q;
    cmd_o.has_fe      = is_dl;
    cmd_o.trunc       = povf_q;
    cmd_o.has_byte    = keep_byte;
    cmd_o.data        = in_byte_i;
    cmd_o.flush_cnt   = keep_byte ? pcnt_q : '0;
    cmd_o.has_line    = line_end;
    cmd_o.line_col    = col_d;
    cmd_o.bracket_err = (depth_d != 8'd0);
    cmd_o.quote_err   = in_quote_d;
    cmd_o.count_err   = chk_count_q && (col_d != exp_fields_q);

    push_o = accept && (is_dl || keep_byte || line_end);

    // line close advances the row and clears the rest of the per-line state, except the flush flag
    row_d = row_q;
    len_d = len_inc;
    if (line_end) begin
      row_d      = (row_q != 16'hFFFF) ? row_q + 16'd1 : row_q;
      col_d      = '0;
      depth_d    = '0;
      in_quote_d = 1'b0;
      skipping_d = 1'b0;
      stopped_d  = 1'b0;
      started_d  = 1'b0;
      len_d      = '0;
      pcnt_d     = '0;
      povf_d     = 1'b0;
    end

    // no new byte while the emitter reads the store
    flush_busy_d = flush_busy_q;
    if (push_o && cmd_o.flush_cnt != '0) begin
      flush_busy_d = 1'b1;
    end else if (flush_done_i) begin
      flush_busy_d = 1'b0;
    end
  end

  assign ram_waddr_o = pcnt_q[AW-1:0];
  assign ram_wdata_o = in_byte_i;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_mode_q <= DM_COMMA_NL;
      end_mode_q   <= EM_NL;
      chk_brace_q  <= 1'b0;
      chk_quote_q  <= 1'b0;
      skip_space_q <= 1'b0;
      chk_count_q  <= 1'b0;
      exp_fields_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_DELIM_MODE: delim_mode_q <= cfg_data_i[2:0];
        REG_END_MODE:   end_mode_q   <= cfg_data_i[1:0];
        REG_CHK_BRACE:  chk_brace_q  <= cfg_data_i[0];
        REG_CHK_QUOTE:  chk_quote_q  <= cfg_data_i[0];
        REG_SKIP_SPACE: skip_space_q <= cfg_data_i[0];
        REG_CHK_COUNT:  chk_count_q  <= cfg_data_i[0];
        REG_EXP_FIELDS: exp_fields_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // line state, advanced per transfer; the flush flag is updated every cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q        <= '0;
      col_q        <= '0;
      depth_q      <= '0;
      in_quote_q   <= 1'b0;
      skipping_q   <= 1'b0;
      stopped_q    <= 1'b0;
      len_q        <= '0;
      started_q    <= 1'b0;
      pcnt_q       <= '0;
      povf_q       <= 1'b0;
      flush_busy_q <= 1'b0;
    end else begin
      flush_busy_q <= flush_busy_d;
      if (accept) begin
        row_q      <= row_d;
        col_q      <= col_d;
        depth_q    <= depth_d;
        in_quote_q <= in_quote_d;
        skipping_q <= skipping_d;
        stopped_q  <= stopped_d;
        len_q      <= len_d;
        started_q  <= started_d;
        pcnt_q     <= pcnt_d;
        povf_q     <= povf_d;
      end
    end
  end

`ifndef SYNTHESIS
  a_store_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we_o |-> (pcnt_q < CNT_W'(PENDING_DEPTH)))
    else $error("whitespace store written past its depth");
  a_len_below_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q < LLW'(LINE_MAX))
    else $error("line length passed the line limit");
`endif

endmodule
`default_nettype wire

// File: rtl/dfs_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dfs_back
// Emitter: pops commands, replays held whitespace from the store, then the
// kept byte or field end and the line report, through one output register.
// ----------------------------------------------------------------------------
module dfs_back
  import dfs_pkg::*;
#(
  parameter int unsigned PENDING_DEPTH = 32,
  parameter int unsigned AW            = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  // command queue
  input  cmd_t               cmd_i,
  input  wire logic          fifo_empty_i,
  output logic               pop_o,
  output logic               flush_done_o,
  // whitespace store read port
  output logic [AW-1:0]      ram_raddr_o,
  input  wire logic [7:0]    ram_rdata_i,
  // result stream
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output res_t               out_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WS_RD,
    ST_WS_OUT,
    ST_BYTE,
    ST_FE,
    ST_LINE
  } state_e;

  state_e           state_q, state_d;
  cmd_t             cmd_q, cmd_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic             out_valid_q, out_valid_d;
  res_t             out_q, out_d;
  logic             slot_free;

  function automatic state_e first_state(input cmd_t c);
    state_e s;
    if (c.has_byte) begin
      s = (c.flush_cnt != '0) ? ST_WS_RD : ST_BYTE;
    end else if (c.has_fe) begin
      s = ST_FE;
    end else begin
      s = ST_LINE;
    end
    return s;
  endfunction

  assign slot_free   = !out_valid_q || out_ready_i;
  assign ram_raddr_o = idx_q[AW-1:0];
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // sequencing of one command
  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    idx_d        = idx_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_d        = out_q;
    pop_o        = 1'b0;
    flush_done_o = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (!fifo_empty_i) begin
          pop_o   = 1'b1;
          cmd_d   = cmd_i;
          idx_d   = '0;
          state_d = first_state(cmd_i);
        end
      end
      ST_WS_RD: begin
        state_d = ST_WS_OUT;
      end
      ST_WS_OUT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_d       = '{kind: KIND_BYTE, data: ram_rdata_i, row: cmd_q.row,
                          col: cmd_q.col, default: 1'b0};
          idx_d       = idx_q + CNT_W'(1);
          if (idx_d == cmd_q.flush_cnt) begin
            flush_done_o = 1'b1;
            state_d      = ST_BYTE;
          end else begin
            state_d = ST_WS_RD;
          end
        end
      end
      ST_BYTE: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_d       = '{kind: KIND_BYTE, data: cmd_q.data, row: cmd_q.row,
                          col: cmd_q.col, last: !cmd_q.has_line, default: 1'b0};
          state_d     = cmd_q.has_line ? ST_LINE : ST_IDLE;
        end
      end
      ST_FE: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_d       = '{kind: KIND_FIELD_END, data: 8'd0, row: cmd_q.row,
                          col: cmd_q.col, trunc: cmd_q.trunc,
                          last: !cmd_q.has_line, default: 1'b0};
          state_d     = cmd_q.has_line ? ST_LINE : ST_IDLE;
        end
      end
      ST_LINE: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_d       = '{kind: KIND_LINE, data: 8'd0, row: cmd_q.row,
                          col: cmd_q.line_col, trunc: 1'b0,
                          bracket_err: cmd_q.bracket_err,
                          quote_err: cmd_q.quote_err,
                          count_err: cmd_q.count_err, last: 1'b1};
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cmd_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      cmd_q       <= cmd_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

`ifndef SYNTHESIS
  a_read_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WS_RD) |-> (cmd_q.flush_cnt != '0) && (idx_q < cmd_q.flush_cnt))
    else $error("store read beyond held whitespace");
  a_pop_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> (state_q == ST_IDLE))
    else $error("command popped while busy");
`endif

endmodule
`default_nettype wire

// File: rtl/delimited_field_splitter_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// delimited_field_splitter_core
// Splits a byte stream into lines and delimited fields, with field end
// markers and per-line error reports.
// ----------------------------------------------------------------------------
//  channel  | signals                              | payload
//  ---------+--------------------------------------+---------------------------
//  s_axis   | tvalid tready tdata[7:0] tlast       | input byte, end of stream
//  m_axis   | tvalid tready tdata[39:0] tuser tlast| result item, kind, last
//  cfg      | cfg_valid_i cfg_ready_o index data   | register write
//
//  A byte is classified in the cycle of its transfer. A byte with no result
//  queues no command; one with results queues a command that the emitter
//  pops and plays out one result at a time, each held whitespace byte with
//  a store read state ahead of its output, as the store read is registered.
//  Input stalls while held whitespace drains and while the two-entry command
//  queue is full. Reset is asynchronous; the whitespace store needs no clearing.
// ----------------------------------------------------------------------------
module delimited_field_splitter_core
  import dfs_pkg::*;
#(
  parameter int unsigned LINE_MAX      = 1024,
  parameter int unsigned PENDING_DEPTH = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [7:0]  cfg_data_i,
  // input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] input_byte
  input  wire logic        s_axis_tlast,   // end_of_stream
  // result stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,   // [7:0] data_byte, [23:8] row,
                                           // [31:24] column, [32] truncated,
                                           // [33] bracket_error,
                                           // [34] quote_error,
                                           // [35] field_count_error, rest zero
  output logic [1:0]       m_axis_tuser,   // [1:0] kind
  output logic             m_axis_tlast    // last
);

  localparam int unsigned AW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;

  cmd_t          push_cmd, pop_cmd;
  logic          push, pop, fifo_full, fifo_empty, flush_done;
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;
  res_t          res;

  assign cfg_ready_o = 1'b1;

  dfs_front #(
    .LINE_MAX      (LINE_MAX),
    .PENDING_DEPTH (PENDING_DEPTH),
    .AW            (AW)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_byte_i    (s_axis_tdata),
    .in_eos_i     (s_axis_tlast),
    .push_o       (push),
    .cmd_o        (push_cmd),
    .fifo_full_i  (fifo_full),
    .flush_done_i (flush_done),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata)
  );

  dfs_ram #(
    .WIDTH (8),
    .DEPTH (PENDING_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  dfs_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .pop_i   (pop),
    .cmd_o   (pop_cmd),
    .full_o  (fifo_full),
    .empty_o (fifo_empty)
  );

  dfs_back #(
    .PENDING_DEPTH (PENDING_DEPTH),
    .AW            (AW)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (pop_cmd),
    .fifo_empty_i (fifo_empty),
    .pop_o        (pop),
    .flush_done_o (flush_done),
    .ram_raddr_o  (ram_raddr),
    .ram_rdata_i  (ram_rdata),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_o        (res)
  );

  // result packing
  assign m_axis_tdata = {4'd0, res.count_err, res.quote_err, res.bracket_err,
                         res.trunc, res.col, res.row, res.data};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;

endmodule
`default_nettype wire

// File: tb/dfs_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dfs_checker
// Scoreboard for the delimited field splitter. Tracks register writes,
// computes the tokens each accepted input byte produces, and compares every
// result transfer field by field against the oldest outstanding token.
// ----------------------------------------------------------------------------
package dfs_tb_pkg;

  // register indexes of the configuration channel
  localparam logic [2:0] REG_DELIM_MODE      = 3'd0;
  localparam logic [2:0] REG_END_MODE        = 3'd1;
  localparam logic [2:0] REG_CHECK_BRACKET   = 3'd2;
  localparam logic [2:0] REG_CHECK_QUOTE     = 3'd3;
  localparam logic [2:0] REG_SKIP_SPACE      = 3'd4;
  localparam logic [2:0] REG_CHECK_COUNT     = 3'd5;
  localparam logic [2:0] REG_EXPECTED_FIELDS = 3'd6;

  // delimiter sets
  localparam logic [2:0] DELIM_COMMA_NL    = 3'd0;
  localparam logic [2:0] DELIM_COMMA_WS    = 3'd1;
  localparam logic [2:0] DELIM_COMMA_SLASH = 3'd2;
  localparam logic [2:0] DELIM_POUND       = 3'd3;
  localparam logic [2:0] DELIM_COMMA_SEMI  = 3'd4;
  localparam logic [2:0] DELIM_UNUSED_HI   = 3'd7;

  // end-of-entry sets
  localparam logic [1:0] END_NEWLINE = 2'd0;
  localparam logic [1:0] END_SPACE   = 2'd1;
  localparam logic [1:0] END_SLASH   = 2'd2;
  localparam logic [1:0] END_SEMI    = 2'd3;

  // characters with a meaning to the splitter
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_POUND  = 8'h23;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

endpackage

module dfs_checker
  import dfs_pkg::*;
  import dfs_tb_pkg::*;
#(
  parameter int unsigned LINE_LIMIT = 1024,
  parameter int unsigned HOLD_DEPTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        s_valid_i,
  input  logic        s_ready_i,
  input  logic [7:0]  s_data_i,
  input  logic        s_last_i,
  input  logic        m_valid_i,
  input  logic        m_ready_i,
  input  logic [39:0] m_data_i,
  input  logic [1:0]  m_user_i,
  input  logic        m_last_i,
  output int unsigned error_count_o,
  output int unsigned outstanding_o,
  output int unsigned checked_o,
  output int unsigned lines_o
);

  // register copies
  logic [2:0]  delim_mode;
  logic [1:0]  end_mode;
  logic        brk_en, quote_en, skip_en, count_en;
  logic [7:0]  want_fields;

  // per-line state
  logic [15:0] row_q;
  logic [7:0]  col_q, depth_q;
  logic        in_quote, skipping, stopped, field_open, hold_ovf;
  int unsigned line_len, hold_cnt;
  logic [7:0]  held_ws [HOLD_DEPTH];

  res_t        token_queue [$];
  int unsigned errors = 0;
  int unsigned checked = 0;
  int unsigned lines = 0;

  function automatic logic is_space(input logic [7:0] c);
    return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic is_newline(input logic [7:0] c);
    return c == CH_CR || c == CH_LF || c == CH_NUL;
  endfunction

  function automatic logic is_delim(input logic [7:0] c);
    case (delim_mode)
      DELIM_COMMA_NL:    return c == CH_COMMA || is_newline(c);
      DELIM_COMMA_WS:    return c == CH_COMMA || is_newline(c) || is_space(c);
      DELIM_COMMA_SLASH: return c == CH_COMMA || is_newline(c) || c == CH_SLASH;
      DELIM_POUND:       return c == CH_POUND;
      DELIM_COMMA_SEMI:  return c == CH_COMMA || is_newline(c) || c == CH_SEMI;
      default:           return 1'b0;
    endcase
  endfunction

  function automatic logic is_end(input logic [7:0] c);
    case (end_mode)
      END_NEWLINE: return is_newline(c);
      END_SPACE:   return is_newline(c) || is_space(c);
      END_SLASH:   return is_newline(c) || c == CH_SLASH;
      default:     return is_newline(c) || c == CH_SEMI;
    endcase
  endfunction

  function automatic res_t make_token(input logic [1:0] kind, input logic [7:0] data,
                                      input logic [7:0] col, input logic trunc,
                                      input logic br_err, input logic qt_err,
                                      input logic cnt_err);
    res_t t;
    t.kind        = kind;
    t.data        = data;
    t.row         = row_q;
    t.col         = col;
    t.trunc       = trunc;
    t.bracket_err = br_err;
    t.quote_err   = qt_err;
    t.count_err   = cnt_err;
    t.last        = 1'b0;
    return t;
  endfunction

  // tokens caused by one input byte, appended in emission order
  task automatic tokenize_byte(input logic [7:0] c, input logic eos);
    res_t        produced [$];
    res_t        tail;
    int unsigned i;
    if (!stopped && !(skipping && is_space(c))) begin
      skipping = 1'b0;
      if (brk_en) begin
        if (c == CH_LBRACE) depth_q = depth_q + 8'd1;
        else if (c == CH_RBRACE) depth_q = depth_q - 8'd1;
      end
      if (quote_en && c == CH_QUOTE) in_quote = !in_quote;

      if (depth_q == 8'd0 && !in_quote && is_delim(c)) begin
        // field closes, held whitespace is thrown away
        produced.push_back(make_token(KIND_FIELD_END, 8'h00, col_q, hold_ovf,
                                      1'b0, 1'b0, 1'b0));
        if (col_q != 8'hFF) col_q++;
        hold_cnt   = 0;
        hold_ovf   = 1'b0;
        field_open = 1'b0;
        if (is_end(c)) stopped = 1'b1;
        else if (skip_en) skipping = 1'b1;
      end else begin
        if (c != CH_QUOTE) begin
          if (is_space(c)) begin
            // whitespace inside a field waits for a later kept byte
            if (field_open) begin
              if (hold_cnt < HOLD_DEPTH) begin
                held_ws[hold_cnt] = c;
                hold_cnt++;
              end else begin
                hold_ovf = 1'b1;
              end
            end
          end else begin
            for (i = 0; i < hold_cnt; i++)
              produced.push_back(make_token(KIND_BYTE, held_ws[i], col_q,
                                            1'b0, 1'b0, 1'b0, 1'b0));
            hold_cnt = 0;
            produced.push_back(make_token(KIND_BYTE, c, col_q, 1'b0, 1'b0, 1'b0, 1'b0));
            field_open = 1'b1;
          end
        end
        if (is_end(c)) stopped = 1'b1;
      end
    end

    // line closes on newline, length limit or end of stream
    line_len++;
    if (c == CH_LF || line_len >= LINE_LIMIT || eos) begin
      produced.push_back(make_token(KIND_LINE, 8'h00, col_q, 1'b0, depth_q != 8'd0,
                                    in_quote, count_en && col_q != want_fields));
      if (row_q != 16'hFFFF) row_q++;
      col_q      = 8'd0;
      depth_q    = 8'd0;
      in_quote   = 1'b0;
      skipping   = 1'b0;
      stopped    = 1'b0;
      field_open = 1'b0;
      line_len   = 0;
      hold_cnt   = 0;
      hold_ovf   = 1'b0;
    end

    if (produced.size() > 0) begin
      tail      = produced.pop_back();
      tail.last = 1'b1;
      produced.push_back(tail);
    end
    foreach (produced[k]) token_queue.push_back(produced[k]);
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      errors++;
    end
  endtask

  // watch all three channels at each edge
  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    if (!rst_ni) begin
      delim_mode  = DELIM_COMMA_NL;
      end_mode    = END_NEWLINE;
      brk_en      = 1'b0;
      quote_en    = 1'b0;
      skip_en     = 1'b0;
      count_en    = 1'b0;
      want_fields = 8'd0;
      row_q       = 16'd0;
      col_q       = 8'd0;
      depth_q     = 8'd0;
      in_quote    = 1'b0;
      skipping    = 1'b0;
      stopped     = 1'b0;
      field_open  = 1'b0;
      hold_ovf    = 1'b0;
      line_len    = 0;
      hold_cnt    = 0;
      token_queue.delete();
    end else begin
      // result transfer against the oldest token
      if (m_valid_i && m_ready_i) begin
        checked++;
        if (m_user_i == KIND_LINE) lines++;
        if (token_queue.size() == 0) begin
          $error("result with no token outstanding: kind %0d data 0x%0h",
                 m_user_i, m_data_i);
          errors++;
        end else begin
          want = token_queue.pop_front();
          check_field("kind", want.kind, m_user_i);
          check_field("data_byte", want.data, m_data_i[7:0]);
          check_field("row", want.row, m_data_i[23:8]);
          check_field("column", want.col, m_data_i[31:24]);
          check_field("truncated", want.trunc, m_data_i[32]);
          check_field("bracket_error", want.bracket_err, m_data_i[33]);
          check_field("quote_error", want.quote_err, m_data_i[34]);
          check_field("field_count_error", want.count_err, m_data_i[35]);
          check_field("tdata padding", 16'd0, m_data_i[39:36]);
          check_field("last", want.last, m_last_i);
        end
      end

      // register write
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_DELIM_MODE:      delim_mode  = cfg_data_i[2:0];
          REG_END_MODE:        end_mode    = cfg_data_i[1:0];
          REG_CHECK_BRACKET:   brk_en      = cfg_data_i[0];
          REG_CHECK_QUOTE:     quote_en    = cfg_data_i[0];
          REG_SKIP_SPACE:      skip_en     = cfg_data_i[0];
          REG_CHECK_COUNT:     count_en    = cfg_data_i[0];
          REG_EXPECTED_FIELDS: want_fields = cfg_data_i;
          default: ;
        endcase
      end

      // input byte transfer
      if (s_valid_i && s_ready_i) tokenize_byte(s_data_i, s_last_i);
    end
    error_count_o <= errors;
    outstanding_o <= token_queue.size();
    checked_o     <= checked;
    lines_o       <= lines;
  end

endmodule

// File: tb/tb_delimited_field_splitter_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_delimited_field_splitter_core
// Drives text bytes and register settings into the splitter under random
// back-pressure on both streams; the checker scores every result transfer.
// Covers all delimiter and end modes, the unused delimiter mode, brace and
// quote tracking, whitespace store overflow and end of stream.
// ----------------------------------------------------------------------------
module tb_delimited_field_splitter_core;
  import dfs_pkg::*;
  import dfs_tb_pkg::*;

  localparam int unsigned LINE_LIMIT    = 1024;
  localparam int unsigned HOLD_DEPTH    = 32;
  localparam int unsigned QUIET_LIMIT   = 2000;
  localparam int unsigned DRAIN_CYCLES  = 16;
  localparam int unsigned SEGMENT_BYTES = 45;

  typedef struct packed {
    logic [2:0] delim;
    logic [1:0] endm;
    logic       brk;
    logic       quo;
    logic       skip;
    logic       cnt;
    logic [7:0] fields;
  } reg_set_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_valid     = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index     = 3'd0;
  logic [7:0]  cfg_data      = 8'd0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'd0;
  logic        s_axis_tlast  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  int unsigned src_idle_pct  = 35;
  int unsigned sink_idle_pct = 68;
  int unsigned quiet_cycles  = 0;
  int unsigned bytes_sent    = 0;
  int unsigned fail_count, outstanding, results_checked, line_reports;

  delimited_field_splitter_core #(
    .LINE_MAX      (LINE_LIMIT),
    .PENDING_DEPTH (HOLD_DEPTH)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  dfs_checker #(
    .LINE_LIMIT (LINE_LIMIT),
    .HOLD_DEPTH (HOLD_DEPTH)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .s_valid_i     (s_axis_tvalid),
    .s_ready_i     (s_axis_tready),
    .s_data_i      (s_axis_tdata),
    .s_last_i      (s_axis_tlast),
    .m_valid_i     (m_axis_tvalid),
    .m_ready_i     (m_axis_tready),
    .m_data_i      (m_axis_tdata),
    .m_user_i      (m_axis_tuser),
    .m_last_i      (m_axis_tlast),
    .error_count_o (fail_count),
    .outstanding_o (outstanding),
    .checked_o     (results_checked),
    .lines_o       (line_reports)
  );

  // 100 MHz clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // random back-pressure on the result stream
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // cycles since the last transfer on any channel
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  // watchdog
  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("Verification failed");
    $finish;
  end

  // one byte transfer, with a random gap ahead of it
  task automatic push_byte(input logic [7:0] b, input logic eos);
    if ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= eos;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
  endtask

  // all registers back to back
  task automatic write_config(input reg_set_t r);
    int idx;
    cfg_valid <= 1'b1;
    for (idx = REG_DELIM_MODE; idx <= REG_EXPECTED_FIELDS; idx++) begin
      cfg_index <= 3'(idx);
      case (3'(idx))
        REG_DELIM_MODE:    cfg_data <= {5'd0, r.delim};
        REG_END_MODE:      cfg_data <= {6'd0, r.endm};
        REG_CHECK_BRACKET: cfg_data <= {7'd0, r.brk};
        REG_CHECK_QUOTE:   cfg_data <= {7'd0, r.quo};
        REG_SKIP_SPACE:    cfg_data <= {7'd0, r.skip};
        REG_CHECK_COUNT:   cfg_data <= {7'd0, r.cnt};
        default:           cfg_data <= r.fields;
      endcase
      do @(posedge clk_i); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  // let every outstanding token arrive, then let the pipeline empty
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [7:0] ws_byte();
    case ($urandom_range(3))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      2:       return CH_VT;
      default: return CH_FF;
    endcase
  endfunction

  // field content, biased toward letters with every special byte mixed in
  function automatic logic [7:0] text_byte();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 40)      return 8'h61 + 8'($urandom_range(25));
    else if (pick < 52) return ws_byte();
    else if (pick < 60) return CH_COMMA;
    else if (pick < 64) return CH_POUND;
    else if (pick < 68) return CH_SEMI;
    else if (pick < 72) return CH_SLASH;
    else if (pick < 78) return CH_LBRACE;
    else if (pick < 84) return CH_RBRACE;
    else if (pick < 90) return CH_QUOTE;
    else                return 8'($urandom_range(255));
  endfunction

  // a line of a few fields with a random separator and terminator
  task automatic send_line();
    int          n_fields, k;
    int unsigned pick;
    n_fields = $urandom_range(1, 5);
    for (k = 0; k < n_fields; k++) begin
      if ($urandom_range(3) == 0) repeat ($urandom_range(1, 3)) push_byte(ws_byte(), 1'b0);
      repeat ($urandom_range(1, 6)) push_byte(text_byte(), 1'b0);
      // whitespace run longer than the store
      if ($urandom_range(11) == 0) begin
        repeat ($urandom_range(HOLD_DEPTH + 1, HOLD_DEPTH + 8)) push_byte(ws_byte(), 1'b0);
        push_byte("z", 1'b0);
      end
      if (k < n_fields - 1) begin
        case ($urandom_range(4))
          0:       push_byte(CH_COMMA, 1'b0);
          1:       push_byte(CH_POUND, 1'b0);
          2:       push_byte(CH_SEMI, 1'b0);
          3:       push_byte(CH_SLASH, 1'b0);
          default: push_byte(CH_SPACE, 1'b0);
        endcase
      end
    end
    pick = $urandom_range(9);
    if (pick < 6) begin
      push_byte(CH_LF, 1'b0);
    end else if (pick == 6) begin
      push_byte(CH_CR, 1'b0);
      push_byte(CH_LF, 1'b0);
    end else if (pick == 7) begin
      push_byte(CH_NUL, 1'b0);
      push_byte(CH_LF, 1'b0);
    end else if (pick == 8) begin
      push_byte(text_byte(), 1'b1);
    end else begin
      push_byte(CH_LF, 1'b1);
    end
  endtask

  // stimulus
  initial begin
    reg_set_t    seg_regs [6];
    int          seg;
    int unsigned seg_start;
    seg_regs[0] = '{DELIM_COMMA_WS,    END_SPACE,   1'b0, 1'b0, 1'b1, 1'b0, 8'd0};
    seg_regs[1] = '{DELIM_COMMA_SLASH, END_SLASH,   1'b1, 1'b0, 1'b1, 1'b1, 8'd3};
    seg_regs[2] = '{DELIM_POUND,       END_SEMI,    1'b0, 1'b1, 1'b0, 1'b1, 8'd1};
    seg_regs[3] = '{DELIM_COMMA_SEMI,  END_SEMI,    1'b1, 1'b1, 1'b1, 1'b1, 8'd4};
    seg_regs[4] = '{DELIM_UNUSED_HI,   END_NEWLINE, 1'b1, 1'b1, 1'b0, 1'b1, 8'd0};
    seg_regs[5] = '{DELIM_COMMA_NL,    END_SPACE,   1'b0, 1'b0, 1'b1, 1'b1, 8'd255};

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: held whitespace, quotes, braces, delimiter that ends the entry
    write_config('{DELIM_COMMA_NL, END_NEWLINE, 1'b1, 1'b1, 1'b0, 1'b1, 8'd2});
    push_byte("a", 1'b0);
    push_byte(CH_SPACE, 1'b0);
    push_byte(CH_TAB, 1'b0);
    push_byte("b", 1'b0);
    push_byte(CH_QUOTE, 1'b0);
    push_byte(CH_COMMA, 1'b0);
    push_byte(CH_QUOTE, 1'b0);
    push_byte(CH_LBRACE, 1'b0);
    push_byte(CH_COMMA, 1'b0);
    push_byte(CH_RBRACE, 1'b0);
    push_byte(CH_COMMA, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(CH_CR, 1'b0);
    push_byte("x", 1'b0);
    push_byte(CH_LF, 1'b0);
    // brace underflow, open field closed by end of stream
    push_byte(CH_RBRACE, 1'b0);
    push_byte("x", 1'b1);
    push_byte(CH_NUL, 1'b0);
    push_byte(8'h7F, 1'b1);
    // quote left open at line end
    push_byte(CH_QUOTE, 1'b0);
    push_byte("q", 1'b0);
    push_byte(CH_LF, 1'b0);
    wait_idle();

    // random lines and noise under each register setting
    for (seg = 0; seg < 6; seg++) begin
      if (seg == 2) begin
        src_idle_pct  = 68;
        sink_idle_pct = 35;
      end else if (seg == 4) begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end
      write_config(seg_regs[seg]);
      seg_start = bytes_sent;
      while (bytes_sent - seg_start < SEGMENT_BYTES) begin
        if ($urandom_range(6) == 0) begin
          repeat ($urandom_range(1, 6))
            push_byte(8'($urandom_range(255)), $urandom_range(15) == 0);
        end else begin
          send_line();
        end
      end
      wait_idle();
    end

    $display("run covered %0d input bytes over all delimiter and end modes,", bytes_sent);
    $display("%0d results checked, %0d line reports, incl. whitespace store overflow",
             results_checked, line_reports);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
